// ===== rtl/gradient_colour_map_defines.svh =====
// Assertion macros shared by the colour map RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef GRADIENT_COLOUR_MAP_DEFINES_SVH
`define GRADIENT_COLOUR_MAP_DEFINES_SVH

// Overlapping implication, checked at every rising edge outside reset.
`define GCM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define GCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gcm_pkg.sv =====
// Package of the gradient colour map: widths, gradient stop tables,
// register map, sequencer states and the palette initialisation function.
// It depends on nothing else.
package gcm_pkg;

  localparam int unsigned MAG_W         = 17;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned RGB_W         = 3 * CH_W;
  localparam int unsigned SCHEME_W      = 3;
  localparam int unsigned NUM_SCHEMES   = 7;
  localparam int unsigned MAX_STOPS     = 7;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned PADDR_W       = 3;

  // Palette memory: one entry per scheme and lower stop, holding both stops.
  localparam int unsigned PAL_ADDR_W = 2 * SCHEME_W;
  localparam int unsigned PAL_DEPTH  = 1 << PAL_ADDR_W;
  localparam int unsigned PAL_W      = 2 * RGB_W;

  localparam logic [SCHEME_W-1:0] SCHEME_RESET = SCHEME_W'(1);
  localparam logic [SCHEME_W-1:0] SCHEME_LAST  = SCHEME_W'(NUM_SCHEMES - 1);

  // Register map, by word index.
  typedef enum logic {
    REG_COLOUR_SCHEME = 1'b0,
    REG_UNMAPPED      = 1'b1
  } gcm_reg_e;

  typedef enum logic {
    ST_INIT,
    ST_RUN
  } gcm_state_e;

  typedef logic [SCHEME_W-1:0] stop_idx_t;

  localparam stop_idx_t GRADIENT_LEN [NUM_SCHEMES] = '{
    3'd7, 3'd7, 3'd7, 3'd5, 3'd5, 3'd2, 3'd5
  };

  localparam logic [RGB_W-1:0] GRADIENT [NUM_SCHEMES][MAX_STOPS] = '{
    // classic
    '{24'h000000, 24'h140050, 24'h0028C8, 24'h00C8C8, 24'h28DC28, 24'hF0F000,
      24'hFFFFFF},
    // inferno
    '{24'h000004, 24'h280B54, 24'h65156E, 24'h9F2A63, 24'hD44842, 24'hF57D15,
      24'hFCFFA4},
    // magma
    '{24'h000004, 24'h1C1044, 24'h4F127B, 24'h812581, 24'hB5367A, 24'hE55C6E,
      24'hFCFDBF},
    // viridis
    '{24'h440154, 24'h3B528B, 24'h21918C, 24'h5EC962, 24'hFDE725, 24'h000000,
      24'h000000},
    // ice
    '{24'h000000, 24'h001450, 24'h0050B4, 24'h28B4FF, 24'hDCFAFF, 24'h000000,
      24'h000000},
    // greyscale
    '{24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
      24'h000000},
    // heat
    '{24'h000000, 24'h780000, 24'hDC2800, 24'hFFB400, 24'hFFFFFF, 24'h000000,
      24'h000000}
  };

  // Scheme code seven has no gradient of its own and falls back to heat.
  function automatic logic [SCHEME_W-1:0] scheme_sat(input logic [SCHEME_W-1:0] sc);
    scheme_sat = (sc > SCHEME_LAST) ? SCHEME_LAST : sc;
  endfunction

  // Contents of one palette entry: the lower stop and the upper stop of a pair.
  function automatic logic [PAL_W-1:0] pal_entry(input logic [PAL_ADDR_W-1:0] addr);
    logic [SCHEME_W-1:0] sc;
    stop_idx_t           last;
    stop_idx_t           i0;
    stop_idx_t           i1;
    sc   = scheme_sat(addr[PAL_ADDR_W-1:SCHEME_W]);
    last = GRADIENT_LEN[sc] - stop_idx_t'(1);
    i0   = (addr[SCHEME_W-1:0] >= last) ? last : addr[SCHEME_W-1:0];
    i1   = (i0 == last) ? last : i0 + stop_idx_t'(1);
    pal_entry = {GRADIENT[sc][i0], GRADIENT[sc][i1]};
  endfunction

endpackage

// ===== rtl/gcm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone: no package needed.
module gcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gradient_colour_map.sv =====
// After reset the block loads all 64 palette entries, with busy_o high, and then
// takes one magnitude item in every cycle. Each result appears on red_o, green_o
// and blue_o after the palette read and the blend are registered, marked by
// done_o for exactly one cycle; the receiver cannot stall, so it must take every
// result in the cycle it appears. The one-read-per-cycle port of the palette
// memory sets the rate of one item per clock. colour_scheme is written over the
// APB port at address 0 and must only change while no item is in flight.
//
// Top level of the gradient colour map. Depends on gcm_pkg, gcm_ram and
// gradient_colour_map_defines.svh.
`include "gradient_colour_map_defines.svh"

module gradient_colour_map import gcm_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [MAG_W-1:0]   magnitude_i,
  output logic               done_o,
  output logic [CH_W-1:0]    red_o,
  output logic [CH_W-1:0]    green_o,
  output logic [CH_W-1:0]    blue_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned TW   = (FRAC_BITS + 1 > MAG_W) ? FRAC_BITS + 1 : MAG_W;
  localparam int unsigned SW   = TW + SCHEME_W;
  localparam int unsigned IW   = SW - FRAC_BITS;
  localparam int unsigned PW   = FRAC_BITS + CH_W + 2;
  localparam logic [TW-1:0] ONE  = TW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [SCHEME_W-1:0] scheme_q, scheme_d;
  logic                reg_hit;

  assign reg_hit = (gcm_reg_e'(paddr[PADDR_W-1]) == REG_COLOUR_SCHEME);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(32 - SCHEME_W){1'b0}}, scheme_q} : 32'd0;

  always_comb begin
    scheme_d = scheme_q;
    if (psel && penable && pwrite && reg_hit) begin
      scheme_d = pwdata[SCHEME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q <= SCHEME_RESET;
    end else begin
      scheme_q <= scheme_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Palette load sequencer
  // ---------------------------------------------------------------------------
  gcm_state_e            state_q, state_d;
  logic [PAL_ADDR_W-1:0] init_cnt_q, init_cnt_d;
  logic                  init_we;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (init_cnt_q == PAL_ADDR_W'(PAL_DEPTH - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN:  state_d = ST_RUN;
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    init_we    = 1'b0;
    busy_o     = 1'b0;
    init_cnt_d = init_cnt_q;
    unique case (state_q)
      ST_INIT: begin
        init_we    = 1'b1;
        busy_o     = 1'b1;
        init_cnt_d = init_cnt_q + PAL_ADDR_W'(1);
      end
      ST_RUN:  init_we = 1'b0;
      default: busy_o  = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      init_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      init_cnt_q <= init_cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: saturate, scale by the segment count and address the palette
  // ---------------------------------------------------------------------------
  logic                  accept;
  logic [SCHEME_W-1:0]   sel;
  logic [SCHEME_W-1:0]   seg_cnt;
  logic [TW-1:0]         mag_ext;
  logic [TW-1:0]         t_sat;
  logic [SW-1:0]         scaled;
  logic [IW-1:0]         seg_raw;
  logic                  at_end;
  logic [SCHEME_W-1:0]   seg_idx;
  logic [FRAC_BITS-1:0]  frac_d, frac_q;
  logic [PAL_ADDR_W-1:0] pal_raddr;
  logic [PAL_W-1:0]      pal_rdata;
  logic                  v1_q, done_q;

  assign accept  = start_i && !busy_o;
  assign sel     = scheme_sat(scheme_q);
  assign seg_cnt = GRADIENT_LEN[sel] - SCHEME_W'(1);
  assign mag_ext = TW'(magnitude_i);
  assign t_sat   = (mag_ext > ONE) ? ONE : mag_ext;
  assign scaled  = SW'(t_sat) * SW'(seg_cnt);
  assign seg_raw = scaled[SW-1:FRAC_BITS];

  // At the last stop the pair collapses onto that stop and the fraction is zero.
  assign at_end    = (seg_raw >= IW'(seg_cnt));
  assign seg_idx   = at_end ? seg_cnt : seg_raw[SCHEME_W-1:0];
  assign frac_d    = at_end ? '0 : scaled[FRAC_BITS-1:0];
  assign pal_raddr = {sel, seg_idx};

  gcm_ram #(
    .WIDTH (PAL_W),
    .DEPTH (PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (init_we),
    .waddr_i (init_cnt_q),
    .wdata_i (pal_entry(init_cnt_q)),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  always_ff @(posedge clk_i) begin
    frac_q <= frac_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: blend each channel as a + (b - a) * f, rounded half up
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0] rgb_q [3];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [CH_W-1:0]        ch_a;
    logic [CH_W-1:0]        ch_b;
    logic signed [CH_W:0]   ch_diff;
    logic signed [PW-1:0]   ch_prod;
    logic signed [PW-1:0]   ch_sum;

    assign ch_a    = pal_rdata[RGB_W + (2 - c) * CH_W +: CH_W];
    assign ch_b    = pal_rdata[(2 - c) * CH_W +: CH_W];
    assign ch_diff = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
    assign ch_prod = PW'(ch_diff) * $signed(PW'({1'b0, frac_q}));
    assign ch_sum  = $signed({2'b00, ch_a, {FRAC_BITS{1'b0}}}) + ch_prod + $signed(HALF);

    always_ff @(posedge clk_i) begin
      rgb_q[c] <= ch_sum[FRAC_BITS +: CH_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      done_q <= v1_q;
    end
  end

  assign done_o  = done_q;
  assign red_o   = rgb_q[0];
  assign green_o = rgb_q[1];
  assign blue_o  = rgb_q[2];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `GCM_ASSERT_IMPL(a_item_gives_result, start_i && !busy_o, ##2 done_o, "item lost in pipeline")
  `GCM_ASSERT_IMPL(a_result_has_item, done_o, $past(start_i && !busy_o, 2), "result without item")
  `GCM_ASSERT_NEXT(a_load_once, !busy_o, !busy_o, "palette load restarted after reset")

endmodule
